// ===== design/mgt_pkg.sv =====
package mgt_pkg;

    localparam int TimeW  = 63;
    localparam int LimitW = 16;
    localparam int DurW   = 32;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    typedef enum logic [2:0] {
        OP_ORDINARY      = 3'd0,
        OP_GROUP_CTRL    = 3'd1,
        OP_RESET         = 3'd2,
        OP_PERSIST_MATCH = 3'd3,
        OP_PERSIST_RISK  = 3'd4,
        OP_BIN_COMMAND   = 3'd5,
        OP_BIN_QUERY     = 3'd6,
        OP_IDLE_POLL     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        REG_MSG_LIMIT    = 2'd0,
        REG_MAX_DURATION = 2'd1,
        REG_PUB_INTERVAL = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    localparam logic [LimitW-1:0] MsgLimitRst    = LimitW'(256);
    localparam logic [DurW-1:0]   MaxDurationRst = DurW'(10000000);
    localparam logic [DurW-1:0]   PubIntervalRst = DurW'(10000000);
    localparam logic [LimitW-1:0] MsgCountMax    = '1;
    localparam logic [TimeW-1:0]  TimeMax        = '1;

    typedef struct packed {
        logic [LimitW-1:0] msg_limit;
        logic [DurW-1:0]   max_duration;
        logic [DurW-1:0]   pub_interval;
    } t_cfg;

    typedef struct packed {
        t_opcode            opcode;
        logic               enable_grouping;
        logic               all_symbols;
        logic [TimeW-1:0]   now_time;
    } t_item;

    typedef struct packed {
        logic [TimeW-1:0] group_number;
        logic             tagged_res;
        logic             publish_request;
        logic             control_success;
    } t_result;

    // now + duration, clamped to the largest time value
    function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                 input logic [DurW-1:0]  b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {{(TimeW + 1 - DurW){1'b0}}, b};
        return s[TimeW] ? TimeMax : s[TimeW-1:0];
    endfunction

endpackage

// ===== design/mgt_cfg_regs.sv =====
module mgt_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mgt_pkg::AddrW-1:0]  paddr,
    input  logic [mgt_pkg::DataW-1:0]  pwdata,
    output logic [mgt_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output mgt_pkg::t_cfg              o_cfg
);

    mgt_pkg::t_cfg      r_cfg;
    mgt_pkg::t_reg_idx  idx;
    logic               wr_en;

    assign idx    = mgt_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msg_limit    <= mgt_pkg::MsgLimitRst;
            r_cfg.max_duration <= mgt_pkg::MaxDurationRst;
            r_cfg.pub_interval <= mgt_pkg::PubIntervalRst;
        end else if (wr_en) begin
            case (idx)
                mgt_pkg::REG_MSG_LIMIT:    r_cfg.msg_limit    <= pwdata[mgt_pkg::LimitW-1:0];
                mgt_pkg::REG_MAX_DURATION: r_cfg.max_duration <= pwdata[mgt_pkg::DurW-1:0];
                mgt_pkg::REG_PUB_INTERVAL: r_cfg.pub_interval <= pwdata[mgt_pkg::DurW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            mgt_pkg::REG_MSG_LIMIT:
                prdata = {{(mgt_pkg::DataW - mgt_pkg::LimitW){1'b0}}, r_cfg.msg_limit};
            mgt_pkg::REG_MAX_DURATION: prdata = r_cfg.max_duration;
            mgt_pkg::REG_PUB_INTERVAL: prdata = r_cfg.pub_interval;
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== design/mgt_core.sv =====
module mgt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mgt_pkg::t_item    i_item,
    input  mgt_pkg::t_cfg     i_cfg,
    output logic              o_has_res,
    output mgt_pkg::t_result  o_res
);

    logic                          r_grouping_on;
    logic [mgt_pkg::TimeW-1:0]     r_group_count;
    logic [mgt_pkg::LimitW-1:0]    r_msgs;
    logic [mgt_pkg::TimeW-1:0]     r_group_deadline;
    logic [mgt_pkg::TimeW-1:0]     r_pub_deadline;
    logic                          r_pub_pending;

    logic                          n_grouping_on;
    logic [mgt_pkg::TimeW-1:0]     n_group_count;
    logic [mgt_pkg::LimitW-1:0]    n_msgs;
    logic [mgt_pkg::TimeW-1:0]     n_group_deadline;
    logic [mgt_pkg::TimeW-1:0]     n_pub_deadline;
    logic                          n_pub_pending;

    logic                          is_idle;
    logic                          is_ctrl;
    logic                          on;
    logic                          open_grp;
    logic                          close_grp;
    logic [mgt_pkg::LimitW-1:0]    msgs_open;
    logic [mgt_pkg::LimitW-1:0]    msgs_inc;
    logic [mgt_pkg::TimeW-1:0]     count_open;

    always_comb begin
        is_idle = (i_item.opcode == mgt_pkg::OP_IDLE_POLL);
        is_ctrl = (i_item.opcode == mgt_pkg::OP_GROUP_CTRL);
        on      = is_ctrl ? i_item.enable_grouping : r_grouping_on;

        open_grp = is_ctrl
                || (i_item.opcode == mgt_pkg::OP_RESET)
                || (i_item.opcode == mgt_pkg::OP_PERSIST_MATCH)
                || (((i_item.opcode == mgt_pkg::OP_BIN_COMMAND)
                  || (i_item.opcode == mgt_pkg::OP_BIN_QUERY)) && i_item.all_symbols);

        msgs_open  = open_grp ? '0 : r_msgs;
        msgs_inc   = (msgs_open == mgt_pkg::MsgCountMax)
                   ? msgs_open
                   : msgs_open + {{(mgt_pkg::LimitW - 1){1'b0}}, 1'b1};
        close_grp  = (msgs_inc >= i_cfg.msg_limit)
                  && (i_item.opcode != mgt_pkg::OP_PERSIST_RISK);
        count_open = r_group_count + {{(mgt_pkg::TimeW - 1){1'b0}}, open_grp};

        n_grouping_on    = r_grouping_on;
        n_group_count    = r_group_count;
        n_msgs           = r_msgs;
        n_group_deadline = r_group_deadline;
        n_pub_deadline   = r_pub_deadline;
        n_pub_pending    = r_pub_pending;
        o_has_res        = 1'b0;
        o_res            = '0;

        if (is_idle) begin
            if ((r_msgs != '0) && (i_item.now_time > r_group_deadline)) begin
                n_group_count = r_group_count + {{(mgt_pkg::TimeW - 1){1'b0}}, 1'b1};
                n_msgs        = '0;
            end
            if (i_item.now_time > r_pub_deadline) begin
                n_pub_deadline = mgt_pkg::sat_add(i_item.now_time, i_cfg.pub_interval);
                n_pub_pending  = 1'b1;
            end
        end else begin
            o_has_res             = 1'b1;
            o_res.control_success = is_ctrl;
            n_grouping_on         = on;
            if (on) begin
                o_res.group_number    = count_open;
                o_res.tagged_res      = 1'b1;
                o_res.publish_request = r_pub_pending;
                n_pub_pending         = 1'b0;
                // open before tagging and close after it can both add one
                n_group_count = r_group_count
                              + {{(mgt_pkg::TimeW - 2){1'b0}},
                                 open_grp & close_grp, open_grp ^ close_grp};
                n_msgs        = close_grp ? '0 : msgs_inc;
            end
            n_group_deadline = mgt_pkg::sat_add(i_item.now_time, i_cfg.max_duration);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grouping_on    <= 1'b1;
            r_group_count    <= '0;
            r_msgs           <= '0;
            r_group_deadline <= '0;
            r_pub_deadline   <= '0;
            r_pub_pending    <= 1'b0;
        end else if (i_fire) begin
            r_grouping_on    <= n_grouping_on;
            r_group_count    <= n_group_count;
            r_msgs           <= n_msgs;
            r_group_deadline <= n_group_deadline;
            r_pub_deadline   <= n_pub_deadline;
            r_pub_pending    <= n_pub_pending;
        end
    end

endmodule

// ===== design/message_group_tagger.sv =====
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------------------
// in        | to block  | i_in_valid / o_in_stall | i_opcode, i_enable_grouping,
//           |           |                         | i_all_symbols, i_now_time
// out       | from block| o_out_valid / i_out_stall| o_group_number, o_tagged_res,
//           |           |                         | o_publish_request, o_control_success
// cfg (APB) | to block  | psel/penable/pready     | paddr, pwdata, prdata
//
// One transaction per cycle sustained while the output is not stalled: input register,
// tagging logic (63-bit compare and add set the path), result register.
// o_out_valid rises once the item has moved from the input register into the result
// register; the result is taken at an edge where i_out_stall is low.
// Idle polls update timers and produce no result transaction.
// Reset is synchronous; all tagging state and config registers take their
// defaults directly, no clearing pass.
// A stalled output holds the result; the input register keeps its item and
// o_in_stall rises only while both stages are full (idle polls never wait).
module message_group_tagger (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_opcode,
    input  logic                        i_enable_grouping,
    input  logic                        i_all_symbols,
    input  logic [mgt_pkg::TimeW-1:0]   i_now_time,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mgt_pkg::TimeW-1:0]   o_group_number,
    output logic                        o_tagged_res,
    output logic                        o_publish_request,
    output logic                        o_control_success,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mgt_pkg::AddrW-1:0]   paddr,
    input  logic [mgt_pkg::DataW-1:0]   pwdata,
    output logic [mgt_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    mgt_pkg::t_cfg     cfg;
    mgt_pkg::t_item    r_in;
    logic              r_in_valid;
    mgt_pkg::t_result  r_out;
    logic              r_out_valid;

    mgt_pkg::t_result  core_res;
    logic              core_has_res;
    logic              out_free;
    logic              fire;
    logic              in_take;

    mgt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // output slot can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // item in the input register is processed; idle polls need no output slot
    assign fire       = r_in_valid && (!core_has_res || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    mgt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_has_res (core_has_res),
        .o_res     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode          <= mgt_pkg::t_opcode'(i_opcode);
            r_in.enable_grouping <= i_enable_grouping;
            r_in.all_symbols     <= i_all_symbols;
            r_in.now_time        <= i_now_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_has_res) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_group_number    = r_out.group_number;
    assign o_tagged_res      = r_out.tagged_res;
    assign o_publish_request = r_out.publish_request;
    assign o_control_success = r_out.control_success;

endmodule
